// ===== src/spnr_pkg.sv =====
`default_nettype none

package spnr_pkg;

    // pixel index width at the ports
    localparam int PIXW = 30;
    // order register width
    localparam int ORDW = 4;
    // default top order for the grid
    localparam int MAX_ORDER_DEF = 13;
    // signed working width, room for 12 * 4^14 and sign
    localparam int WW = 36;
    // square root operand width
    localparam int SQW = 32;
    // in-face coordinate width
    localparam int CW = 16;

    typedef logic signed [WW-1:0] sw_t;

    // per-item payload that travels down the pipe
    typedef struct packed {
        logic            req;
        logic            err;
        logic            north;
        logic            south;
        logic            kshift;
        logic [ORDW-1:0] ord;
        logic [3:0]      face;
        logic [CW-1:0]   x;
        logic [CW-1:0]   y;
        sw_t             pix;
        sw_t             ip;
        sw_t             r;
        sw_t             m;
        sw_t             iring;
        sw_t             iphi;
        sw_t             jr;
        sw_t             ring_base;
        sw_t             jp;
        sw_t             irt;
        sw_t             ipt;
        sw_t             res;
    } pl_t;

    function automatic logic [2:0] face_row(input logic [3:0] f);
        logic [2:0] v;
        unique case (f)
            4'd0, 4'd1, 4'd2, 4'd3: v = 3'd2;
            4'd4, 4'd5, 4'd6, 4'd7: v = 3'd3;
            default:                v = 3'd4;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] face_col(input logic [3:0] f);
        logic [2:0] v;
        unique case (f)
            4'd0:    v = 3'd1;
            4'd1:    v = 3'd3;
            4'd2:    v = 3'd5;
            4'd3:    v = 3'd7;
            4'd4:    v = 3'd0;
            4'd5:    v = 3'd2;
            4'd6:    v = 3'd4;
            4'd7:    v = 3'd6;
            4'd8:    v = 3'd1;
            4'd9:    v = 3'd3;
            4'd10:   v = 3'd5;
            default: v = 3'd7;
        endcase
        return v;
    endfunction

    // bits 0,2,4,... packed together
    function automatic logic [CW-1:0] gather16(input logic [2*CW-1:0] v);
        logic [CW-1:0] r;
        for (int i = 0; i < CW; i++) begin
            r[i] = v[2*i];
        end
        return r;
    endfunction

    // consecutive bits onto bits 0,2,4,...
    function automatic logic [2*CW-1:0] spread16(input logic [CW-1:0] v);
        logic [2*CW-1:0] r;
        r = '0;
        for (int i = 0; i < CW; i++) begin
            r[2*i] = v[i];
        end
        return r;
    endfunction

    function automatic sw_t f_side(input logic [ORDW-1:0] o);
        return sw_t'(1) << o;
    endfunction

    function automatic sw_t f_npix(input logic [ORDW-1:0] o);
        sw_t sq;
        sq = sw_t'(1) << {o, 1'b0};
        return (sq << 3) + (sq << 2);
    endfunction

    function automatic sw_t f_ncap(input logic [ORDW-1:0] o);
        sw_t sq;
        sq = sw_t'(1) << {o, 1'b0};
        return (sq << 1) - (f_side(o) << 1);
    endfunction

    // small constant times r by shift and add
    function automatic sw_t mul_col(input sw_t r, input logic [2:0] c);
        sw_t s;
        s = '0;
        if (c[2]) s = s + (r << 2);
        if (c[1]) s = s + (r << 1);
        if (c[0]) s = s + r;
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== src/sphere_pixel_nest_ring_convert_top.sv =====
// A result strobes done once its item has passed through all pipe stages.
// Throughput: one item per cycle; busy stays low, start may be held every cycle.
// The pipe is the 16-stage square root pipe plus nine control stages.
// The receiver cannot stall: each result is on pix_out/range_error for one cycle.
// Reset (async, rst_n low) empties the pipe and sets order to 0.
`default_nettype none

module sphere_pixel_nest_ring_convert_top #(
    parameter int MAX_ORDER = spnr_pkg::MAX_ORDER_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [spnr_pkg::ORDW-1:0]   cfg_wdata,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        req_type,
    input  wire logic [spnr_pkg::PIXW-1:0]   pix_in,
    output logic                             done,
    output logic [spnr_pkg::PIXW-1:0]        pix_out,
    output logic                             range_error
);
    import spnr_pkg::*;

    localparam int LATENCY = 25;

    // ------------------------------------------------------------------
    // configuration: grid order, taken with each item at entry
    // ------------------------------------------------------------------
    logic [ORDW-1:0] order_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            order_reg <= '0;
        end
        else if (cfg_we) begin
            order_reg <= cfg_wdata;
        end
    end

    // never stalls
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // valid bits for all stages outside the root pipe
    // ------------------------------------------------------------------
    logic       s0_vld_reg;
    logic       sa_vld_reg;
    logic [6:1] v_reg;
    logic       done_reg;
    logic       sq_vld;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s0_vld_reg <= 1'b0;
            sa_vld_reg <= 1'b0;
            v_reg      <= '0;
            done_reg   <= 1'b0;
        end
        else begin
            s0_vld_reg <= start && !busy;
            sa_vld_reg <= s0_vld_reg;
            v_reg      <= {v_reg[5:1], sq_vld};
            done_reg   <= v_reg[6];
        end
    end

    // ------------------------------------------------------------------
    // stage 0: capture item
    // ------------------------------------------------------------------
    logic            req0_reg;
    logic [PIXW-1:0] pix0_reg;
    logic [ORDW-1:0] ord0_reg;

    always_ff @(posedge clk) begin
        if (start && !busy) begin
            req0_reg <= req_type;
            pix0_reg <= pix_in;
            ord0_reg <= order_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage A: range check, region, root operand, face and x/y split
    // ------------------------------------------------------------------
    pl_t            sa_next;
    pl_t            sa_reg;
    logic [SQW-1:0] sarg_next;
    logic [SQW-1:0] sarg_reg;

    always_comb begin
        sw_t           n;
        sw_t           npix;
        sw_t           ncap;
        sw_t           p;
        sw_t           sq;
        sw_t           ipv;
        sw_t           sa;
        logic [PIXW-1:0] fsh;
        logic [PIXW-1:0] ipf;

        n    = f_side(ord0_reg);
        npix = f_npix(ord0_reg);
        ncap = f_ncap(ord0_reg);
        sq   = sw_t'(1) << {ord0_reg, 1'b0};
        p    = sw_t'(pix0_reg);

        sa_next        = '0;
        sa_next.req    = req0_reg;
        sa_next.ord    = ord0_reg;
        sa_next.pix    = p;
        sa_next.err    = (int'(ord0_reg) > MAX_ORDER) || (p >= npix);
        sa_next.north  = p < ncap;
        sa_next.south  = p >= (npix - ncap);
        ipv            = sa_next.south ? (npix - p) : (p - ncap);
        sa_next.ip     = ipv;

        fsh            = pix0_reg >> {ord0_reg, 1'b0};
        sa_next.face   = (fsh > PIXW'(11)) ? 4'd11 : fsh[3:0];
        ipf            = pix0_reg & (sq[PIXW-1:0] - PIXW'(1));
        sa_next.x      = gather16({2'b00, ipf});
        sa_next.y      = gather16({3'b000, ipf[PIXW-1:1]});

        if (!req0_reg) begin
            sa = '0;
        end
        else if (sa_next.north) begin
            sa = (p << 1) + 1;
        end
        else if (sa_next.south) begin
            sa = (ipv << 1) - 1;
        end
        else begin
            sa = '0;
        end
        sarg_next = sa[SQW-1:0];
        // n is used only in this test; it is at least 1, so sarg_next is never cleared here
        if (n == '0) begin
            sarg_next = '0;
        end
    end

    always_ff @(posedge clk) begin
        sa_reg   <= sa_next;
        sarg_reg <= sarg_next;
    end

    // ------------------------------------------------------------------
    // polar ring number by exact integer root
    // ------------------------------------------------------------------
    pl_t               sq_pl;
    logic [SQW/2-1:0]  sq_root;

    spnr_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (sa_vld_reg),
        .in_pl    (sa_reg),
        .in_arg   (sarg_reg),
        .out_vld  (sq_vld),
        .out_pl   (sq_pl),
        .out_root (sq_root)
    );

    // ------------------------------------------------------------------
    // P1: ring number / ring class
    // ------------------------------------------------------------------
    pl_t p1_next, p1_reg;

    always_comb begin
        sw_t n;
        sw_t hs;
        sw_t jr;

        p1_next = sq_pl;
        n       = f_side(sq_pl.ord);
        hs      = (sw_t'(sq_root) + 1) >>> 1;
        jr      = (sw_t'(face_row(sq_pl.face)) << sq_pl.ord)
                  - sw_t'(sq_pl.x) - sw_t'(sq_pl.y) - 1;
        p1_next.kshift = 1'b0;
        if (!sq_pl.req) begin
            p1_next.jr    = jr;
            p1_next.north = 1'b0;
            p1_next.south = 1'b0;
            if (jr < n) begin
                p1_next.r     = jr;
                p1_next.north = 1'b1;
            end
            else if (jr > ((n << 1) + n)) begin
                p1_next.r     = (n << 2) - jr;
                p1_next.south = 1'b1;
            end
            else begin
                p1_next.r      = n;
                p1_next.kshift = jr[0] ^ n[0];
            end
        end
        else if (sq_pl.north) begin
            p1_next.r     = hs;
            p1_next.iring = hs;
        end
        else if (sq_pl.south) begin
            p1_next.r     = hs;
            p1_next.iring = (n << 2) - hs;
        end
        else begin
            p1_next.iring  = (sq_pl.ip >>> ({1'b0, sq_pl.ord} + 5'd2)) + n;
            p1_next.iphi   = (sq_pl.ip & ((n << 2) - 1)) + 1;
            p1_next.kshift = p1_next.iring[0] ^ n[0];
            p1_next.r      = n;
        end
    end

    // ------------------------------------------------------------------
    // P2: r*(r-1); equatorial face for ring input
    // ------------------------------------------------------------------
    pl_t p2_next, p2_reg;

    always_comb begin
        sw_t         n;
        logic [14:0] r15;
        logic [14:0] rm1;
        logic [29:0] prod;
        sw_t         ire;
        sw_t         irm;
        sw_t         ifm;
        sw_t         ifp;

        p2_next = p1_reg;
        n       = f_side(p1_reg.ord);
        r15     = p1_reg.r[14:0];
        rm1     = r15 - 15'd1;
        prod    = r15 * rm1;
        p2_next.m = sw_t'(prod);

        ire = p1_reg.iring - n + 1;
        irm = (n << 1) + 2 - ire;
        ifm = (p1_reg.iphi - (ire >>> 1) + n - 1) >>> p1_reg.ord;
        ifp = (p1_reg.iphi - (irm >>> 1) + n - 1) >>> p1_reg.ord;
        if (p1_reg.req && !p1_reg.north && !p1_reg.south) begin
            if (ifp == ifm) begin
                p2_next.face = (ifp == sw_t'(4)) ? 4'd4 : 4'(ifp + 4);
            end
            else if (ifp < ifm) begin
                p2_next.face = 4'(ifp);
            end
            else begin
                p2_next.face = 4'(ifm + 8);
            end
        end
    end

    // ------------------------------------------------------------------
    // P3: pixels ahead of the ring and raw position (nested in);
    //     position in ring (polar ring in)
    // ------------------------------------------------------------------
    pl_t p3_next, p3_reg;

    always_comb begin
        sw_t n;
        sw_t npix;
        sw_t ncap;

        p3_next = p2_reg;
        n       = f_side(p2_reg.ord);
        npix    = f_npix(p2_reg.ord);
        ncap    = f_ncap(p2_reg.ord);
        if (!p2_reg.req) begin
            if (p2_reg.north) begin
                p3_next.ring_base = p2_reg.m << 1;
            end
            else if (p2_reg.south) begin
                p3_next.ring_base = npix - (p2_reg.m << 1) - (p2_reg.r << 2);
            end
            else begin
                p3_next.ring_base = ncap
                    + ((p2_reg.jr - n) << ({1'b0, p2_reg.ord} + 5'd2));
            end
            p3_next.jp = (mul_col(p2_reg.r, face_col(p2_reg.face))
                          + sw_t'(p2_reg.x) - sw_t'(p2_reg.y) + 1
                          + sw_t'(p2_reg.kshift)) >>> 1;
        end
        else if (p2_reg.north) begin
            p3_next.iphi = p2_reg.pix + 1 - (p2_reg.m << 1);
        end
        else if (p2_reg.south) begin
            p3_next.iphi = (p2_reg.r << 2) + 1 - (p2_reg.ip - (p2_reg.m << 1));
        end
    end

    // ------------------------------------------------------------------
    // P4: wrap and sum (nested in); polar face (ring in)
    // ------------------------------------------------------------------
    pl_t p4_next, p4_reg;

    always_comb begin
        sw_t        n4;
        sw_t        jw;
        sw_t        tmp;
        logic [3:0] fc;

        p4_next = p3_reg;
        n4      = f_side(p3_reg.ord) << 2;
        priority if (p3_reg.jp > n4) begin
            jw = p3_reg.jp - n4;
        end
        else if (p3_reg.jp < 1) begin
            jw = p3_reg.jp + n4;
        end
        else begin
            jw = p3_reg.jp;
        end
        tmp = p3_reg.iphi - 1;
        fc  = p3_reg.south ? 4'd8 : 4'd0;
        if (tmp >= (p3_reg.r << 1)) begin
            fc  = fc + 4'd2;
            tmp = tmp - (p3_reg.r << 1);
        end
        if (tmp >= p3_reg.r) begin
            fc = fc + 4'd1;
        end
        if (!p3_reg.req) begin
            p4_next.res = p3_reg.ring_base + jw - 1;
        end
        else if (p3_reg.north || p3_reg.south) begin
            p4_next.face = fc;
        end
    end

    // ------------------------------------------------------------------
    // P5: in-face ring and position (ring in)
    // ------------------------------------------------------------------
    pl_t p5_next, p5_reg;

    always_comb begin
        sw_t n;
        sw_t ipt;

        p5_next     = p4_reg;
        n           = f_side(p4_reg.ord);
        p5_next.irt = p4_reg.iring
                      - (sw_t'(face_row(p4_reg.face)) << p4_reg.ord) + 1;
        ipt         = (p4_reg.iphi << 1) - mul_col(p4_reg.r, face_col(p4_reg.face))
                      - sw_t'(p4_reg.kshift) - 1;
        if (ipt >= (n << 1)) begin
            ipt = ipt - (n << 3);
        end
        p5_next.ipt = ipt;
    end

    // ------------------------------------------------------------------
    // P6: x/y and bit interleave (ring in)
    // ------------------------------------------------------------------
    pl_t p6_next, p6_reg;

    always_comb begin
        sw_t           xv;
        sw_t           yv;
        sw_t           nm1;
        logic [CW-1:0] nm;

        p6_next = p5_reg;
        nm1     = f_side(p5_reg.ord) - 1;
        nm      = nm1[CW-1:0];
        xv      = (p5_reg.ipt - p5_reg.irt) >>> 1;
        yv      = (-(p5_reg.ipt + p5_reg.irt)) >>> 1;
        if (p5_reg.req) begin
            p6_next.res = (sw_t'(p5_reg.face) << {p5_reg.ord, 1'b0})
                        | sw_t'(spread16(xv[CW-1:0] & nm))
                        | (sw_t'(spread16(yv[CW-1:0] & nm)) << 1);
        end
    end

    always_ff @(posedge clk) begin
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        p3_reg <= p3_next;
        p4_reg <= p4_next;
        p5_reg <= p5_next;
        p6_reg <= p6_next;
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [PIXW-1:0] pix_out_reg;
    logic            range_error_reg;

    always_ff @(posedge clk) begin
        pix_out_reg     <= p6_reg.err ? '0 : p6_reg.res[PIXW-1:0];
        range_error_reg <= p6_reg.err;
    end

    assign done        = done_reg;
    assign pix_out     = pix_out_reg;
    assign range_error = range_error_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item taken but no result after pipeline latency");

    a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching item");

    a_face: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[5] && p5_reg.req && !p5_reg.err) |-> (p5_reg.face <= 4'd11))
        else $error("face number out of range on ring input");

endmodule

`default_nettype wire

// ===== src/spnr_isqrt.sv =====
`default_nettype none

// pipelined integer square root, one result bit per stage
module spnr_isqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_vld,
    input  wire spnr_pkg::pl_t              in_pl,
    input  wire logic [spnr_pkg::SQW-1:0]   in_arg,
    output logic                            out_vld,
    output spnr_pkg::pl_t                   out_pl,
    output logic [spnr_pkg::SQW/2-1:0]      out_root
);
    import spnr_pkg::*;

    localparam int NS = SQW / 2;

    logic [NS-1:0]  vld_reg;
    pl_t            pl_reg  [NS];
    logic [SQW-1:0] rem_reg [NS];
    logic [SQW-1:0] res_reg [NS];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            vld_reg <= {vld_reg[NS-2:0], in_vld};
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * k);
        logic [SQW-1:0] rem_i;
        logic [SQW-1:0] res_i;
        logic [SQW-1:0] t_w;
        pl_t            pl_i;

        if (k == 0) begin : g_first
            assign rem_i = in_arg;
            assign res_i = '0;
            assign pl_i  = in_pl;
        end
        else begin : g_next
            assign rem_i = rem_reg[k-1];
            assign res_i = res_reg[k-1];
            assign pl_i  = pl_reg[k-1];
        end

        assign t_w = res_i + BIT;

        always_ff @(posedge clk) begin
            pl_reg[k] <= pl_i;
            if (rem_i >= t_w) begin
                rem_reg[k] <= rem_i - t_w;
                res_reg[k] <= (res_i >> 1) + BIT;
            end
            else begin
                rem_reg[k] <= rem_i;
                res_reg[k] <= res_i >> 1;
            end
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign out_pl   = pl_reg[NS-1];
    assign out_root = res_reg[NS-1][NS-1:0];

endmodule

`default_nettype wire

// ===== tb/sphere_pixel_nest_ring_convert_top_tb.sv =====
`timescale 1ns / 1ps

module sphere_pixel_nest_ring_convert_top_tb;
    import spnr_pkg::*;

    // Expected conversion result for one item
    typedef struct {
        logic [PIXW-1:0] pix;
        logic            err;
    } conv_t;

    localparam int TOP_ORDER  = 13;
    localparam int LATENCY    = 25;
    localparam int CYCLE_CAP  = 400000;
    localparam logic NEST2RING = 1'b0;
    localparam logic RING2NEST = 1'b1;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [ORDW-1:0] cfg_wdata;
    logic            start;
    logic            busy;
    logic            req_type;
    logic [PIXW-1:0] pix_in;
    logic            done;
    logic [PIXW-1:0] pix_out;
    logic            range_error;

    conv_t           pending_q[$];   // results still owed by the block
    logic [ORDW-1:0] tb_order;       // mirror of the order register
    int              fail_cnt;
    int              item_cnt;
    int              result_cnt;
    int              cycle_cnt;
    bit              gaps_on;        // random idle bursts on the sender side

    sphere_pixel_nest_ring_convert_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .pix_in      (pix_in),
        .done        (done),
        .pix_out     (pix_out),
        .range_error (range_error)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ---------------------------------------------------------------
    // Predictor: bit-exact integer conversion between the two orderings
    // ---------------------------------------------------------------
    function automatic longint unsigned pick_even(input longint unsigned v);
        longint unsigned r;
        r = 0;
        for (int i = 0; i < 16; i++)
            r |= ((v >> (2 * i)) & 1) << i;
        return r;
    endfunction

    function automatic longint unsigned deal_even(input longint unsigned v);
        longint unsigned r;
        r = 0;
        for (int i = 0; i < 16; i++)
            r |= ((v >> i) & 1) << (2 * i);
        return r;
    endfunction

    // floor of the square root, found bit by bit from the top
    function automatic longint root_floor(input longint v);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--)
            if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= v)
                r = r + (64'sd1 << b);
        return r;
    endfunction

    function automatic longint row_of(input longint f);
        return (f < 4) ? 2 : (f < 8) ? 3 : 4;
    endfunction

    function automatic longint col_of(input longint f);
        longint m;
        m = f % 4;
        return (f >= 4 && f < 8) ? 2 * m : 2 * m + 1;
    endfunction

    function automatic longint nest_ring(input int ord, input longint pix);
        longint n, f, ipf, x, y, jr, nr, offs, ks, jp;
        n   = 64'sd1 << ord;
        f   = pix >> (2 * ord);
        ipf = pix & (n * n - 1);
        x   = pick_even(ipf);
        y   = pick_even(ipf >> 1);
        if (f > 11)
            f = 11;
        jr = row_of(f) * n - x - y - 1;
        if (jr < n)
        begin
            nr   = jr;
            offs = 2 * nr * (nr - 1);
            ks   = 0;
        end
        else if (jr > 3 * n)
        begin
            nr   = 4 * n - jr;
            offs = 12 * n * n - 2 * (nr + 1) * nr;
            ks   = 0;
        end
        else
        begin
            nr   = n;
            offs = 2 * (n * n - n) + (jr - n) * 4 * n;
            ks   = (jr - n) & 1;
        end
        jp = (col_of(f) * nr + x - y + 1 + ks) >>> 1;
        if (jp > 4 * n)
            jp -= 4 * n;
        else if (jp < 1)
            jp += 4 * n;
        return offs + jp - 1;
    endfunction

    function automatic longint ring_nest(input int ord, input longint p);
        longint n, ncap, iring, iphi, ks, nr, face, t, irt, ipt, x, y;
        longint ip, ire, irm, ifm, ifp;
        n    = 64'sd1 << ord;
        ncap = 2 * (n * n - n);
        if (p < ncap)
        begin
            // north polar cap
            iring = (1 + root_floor(2 * p + 1)) >> 1;
            iphi  = p + 1 - 2 * iring * (iring - 1);
            ks    = 0;
            nr    = iring;
            face  = 0;
            t     = iphi - 1;
            if (t >= 2 * iring)
            begin
                face = 2;
                t   -= 2 * iring;
            end
            if (t >= iring)
                face++;
        end
        else if (p < 12 * n * n - ncap)
        begin
            // equatorial belt
            ip    = p - ncap;
            iring = (ip >> (ord + 2)) + n;
            iphi  = (ip & (4 * n - 1)) + 1;
            ks    = (iring + n) & 1;
            nr    = n;
            ire   = iring - n + 1;
            irm   = 2 * n + 2 - ire;
            ifm   = (iphi - ire / 2 + n - 1) >>> ord;
            ifp   = (iphi - irm / 2 + n - 1) >>> ord;
            if (ifp == ifm)
                face = (ifp == 4) ? 4 : ifp + 4;
            else if (ifp < ifm)
                face = ifp;
            else
                face = ifm + 8;
        end
        else
        begin
            // south polar cap
            ip    = 12 * n * n - p;
            nr    = (1 + root_floor(2 * ip - 1)) >> 1;
            iphi  = 4 * nr + 1 - (ip - 2 * nr * (nr - 1));
            ks    = 0;
            iring = 4 * n - nr;
            face  = 8;
            t     = iphi - 1;
            if (t >= 2 * nr)
            begin
                face = 10;
                t   -= 2 * nr;
            end
            if (t >= nr)
                face++;
        end
        if (face < 0 || face > 11)
            face = 0;
        irt = iring - row_of(face) * n + 1;
        ipt = 2 * iphi - col_of(face) * nr - ks - 1;
        if (ipt >= 2 * n)
            ipt -= 8 * n;
        x = (ipt - irt) >>> 1;
        y = (-(ipt + irt)) >>> 1;
        return (face << (2 * ord)) | deal_even(x & (n - 1)) | (deal_even(y & (n - 1)) << 1);
    endfunction

    function automatic conv_t convert_pixel(input logic [ORDW-1:0] ord, input logic rt,
                                            input logic [PIXW-1:0] pix);
        conv_t  c;
        longint npix;
        c.pix = '0;
        c.err = 1'b0;
        if (ord > TOP_ORDER)
            c.err = 1'b1;
        else
        begin
            npix = 12 * (64'sd1 << (2 * ord));
            if (longint'(pix) >= npix)
                c.err = 1'b1;
            else if (rt == NEST2RING)
                c.pix = PIXW'(nest_ring(int'(ord), longint'(pix)));
            else
                c.pix = PIXW'(ring_nest(int'(ord), longint'(pix)));
        end
        return c;
    endfunction

    // ---------------------------------------------------------------
    // Monitor: checks each strobed result against the oldest expectation,
    // then books the item taken on this edge. A result never comes on the edge
    // that books its item, so checking first never sees the same-edge booking.
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        conv_t want;
        if (!rst_n)
        begin
            tb_order = '0;
        end
        else
        begin
            if (done)
            begin
                result_cnt++;
                if (pending_q.size() == 0)
                begin
                    $error("result with nothing pending: pix_out=%0d range_error=%0b",
                           pix_out, range_error);
                    fail_cnt++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (pix_out !== want.pix)
                    begin
                        $error("pix_out expected %0d actual %0d", want.pix, pix_out);
                        fail_cnt++;
                    end
                    if (range_error !== want.err)
                    begin
                        $error("range_error expected %0b actual %0b", want.err, range_error);
                        fail_cnt++;
                    end
                end
            end
            if (start && !busy)
            begin
                pending_q.push_back(convert_pixel(tb_order, req_type, pix_in));
                item_cnt++;
            end
            if (cfg_we)
                tb_order = cfg_wdata;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers. All drive happens at the falling edge; each task
    // starts and ends on a falling edge. start stays high between
    // back-to-back items and is lowered only for a gap or a pause.
    // ---------------------------------------------------------------
    task automatic send_item(input logic rt, input logic [PIXW-1:0] pix);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        start    = 1'b1;
        req_type = rt;
        pix_in   = pix;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // wait for the pipe to drain
    task automatic drain_pipe();
        start = 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    // order writes only while the pipe is empty
    task automatic write_order(input logic [ORDW-1:0] o);
        drain_pipe();
        cfg_we    = 1'b1;
        cfg_wdata = o;
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_wdata = ORDW'($urandom_range(0, 15));
        @(negedge clk);
    endtask

    function automatic logic [PIXW-1:0] rand_pix(input logic [ORDW-1:0] o);
        longint npix;
        npix = 12 * (64'sd1 << (2 * (o > TOP_ORDER ? TOP_ORDER : o)));
        case ($urandom_range(0, 9))
            0:       return PIXW'($urandom);          // full width, mostly out of range below the top order
            1:       return PIXW'(npix - 1 - $urandom_range(0, 3));
            2:       return PIXW'(npix + $urandom_range(0, 3));
            default: return PIXW'($urandom_range(0, int'(npix - 1)));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // order 0 after reset: the 12 base pixels, even ones nest to ring, odd ones ring to nest, plus out of range
    task automatic test_base_faces();
        for (int i = 0; i < 12; i += 2)
        begin
            send_item(NEST2RING, PIXW'(i));
            send_item(RING2NEST, PIXW'(i + 1));
        end
        send_item(NEST2RING, PIXW'(12));
        send_item(RING2NEST, '1);
    endtask

    // largest order: edge and middle indexes, first out-of-range index, all ones
    task automatic test_top_order();
        longint npix;
        write_order(ORDW'(TOP_ORDER));
        npix = 12 * (64'sd1 << (2 * TOP_ORDER));
        send_item(NEST2RING, '0);
        send_item(RING2NEST, '0);
        send_item(NEST2RING, PIXW'(npix - 1));
        send_item(RING2NEST, PIXW'(npix - 1));
        send_item(RING2NEST, PIXW'(npix / 2));
        send_item(NEST2RING, PIXW'(npix));
        send_item(RING2NEST, '1);
    endtask

    // orders beyond the top always flag range_error
    task automatic test_bad_order();
        write_order(4'd14);
        send_item(NEST2RING, '0);
        send_item(RING2NEST, PIXW'(5));
        write_order(4'd15);
        send_item(NEST2RING, '0);
        send_item(RING2NEST, '1);
    endtask

    // random conversions across a series of orders, mostly small
    task automatic test_random_orders(input int n_items);
        logic [ORDW-1:0] o;
        for (int k = 0; k < 8; k++)
        begin
            case (k)
                0:       o = 4'd1;
                3:       o = ORDW'(TOP_ORDER);
                6:       o = 4'd15;
                default: o = ($urandom_range(0, 4) == 0) ? ORDW'($urandom_range(7, 13))
                                                         : ORDW'($urandom_range(0, 6));
            endcase
            write_order(o);
            for (int i = 0; i < n_items / 8; i++)
                send_item(1'($urandom_range(0, 1)), rand_pix(o));
        end
    endtask

    // sender holds off until every pending result has come
    task automatic test_pause();
        for (int i = 0; i < 10; i++)
            send_item(1'($urandom_range(0, 1)), rand_pix(tb_order));
        drain_pipe();
        for (int i = 0; i < 10; i++)
            send_item(1'($urandom_range(0, 1)), rand_pix(tb_order));
    endtask

    // back to back at full rate, no gaps
    task automatic test_full_rate(input int n_items);
        gaps_on = 1'b0;
        write_order(4'd3);
        for (int i = 0; i < n_items; i++)
            send_item(1'($urandom_range(0, 1)), rand_pix(4'd3));
        write_order(ORDW'(TOP_ORDER));
        for (int i = 0; i < n_items; i++)
            send_item(1'($urandom_range(0, 1)), rand_pix(ORDW'(TOP_ORDER)));
    endtask

    initial
    begin
        fail_cnt   = 0;
        item_cnt   = 0;
        result_cnt = 0;
        cycle_cnt  = 0;
        gaps_on    = 1'b1;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        start      = 1'b0;
        req_type   = 1'b0;
        pix_in     = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_base_faces();
        test_top_order();
        test_bad_order();
        test_random_orders(320);
        test_pause();
        test_full_rate(30);

        // let the last results out
        start = 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);

        $display("covered %0d items, %0d results: both directions, orders 0..15,",
                 item_cnt, result_cnt);
        $display("in-range and out-of-range indexes, gaps, a full drain and full rate");
        if (fail_cnt == 0 && pending_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
